>>> rtl/drq_pkg.sv
// Shared types, widths and the control store for the dense rank query engine.
// Used by drq_useq, drq_dpath and dense_rank_query_engine; depends on nothing.
package drq_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned RANK_W  = 11;
  localparam int unsigned STEP_W  = 4;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  // Datapath actions, one per control word.
  typedef enum logic [2:0] {
    A_NONE,
    A_FETCH,
    A_INIT,
    A_READ,
    A_CMP,
    A_EMIT,
    A_CLEAR,
    A_LOAD
  } act_e;

  // Jump conditions: jump to target when true, otherwise step on.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_REQ,
    C_OP_CLEAR,
    C_OP_LOAD,
    C_OP_OTHER,
    C_DONE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic req;
    logic op_clear;
    logic op_load;
    logic op_query;
    logic done;
    logic out_busy;
  } flags_t;

  localparam step_t S_FETCH  = 4'd0;
  localparam step_t S_DEC_C  = 4'd1;
  localparam step_t S_DEC_L  = 4'd2;
  localparam step_t S_INIT   = 4'd3;
  localparam step_t S_PROBE  = 4'd4;
  localparam step_t S_CMP    = 4'd5;
  localparam step_t S_EMIT   = 4'd6;
  localparam step_t S_RET    = 4'd7;
  localparam step_t S_CLEAR  = 4'd8;
  localparam step_t S_LOAD   = 4'd9;

  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    unique case (step)
      S_FETCH: w = '{act: A_FETCH, cond: C_NO_REQ,   target: S_FETCH};
      S_DEC_C: w = '{act: A_NONE,  cond: C_OP_CLEAR, target: S_CLEAR};
      S_DEC_L: w = '{act: A_NONE,  cond: C_OP_LOAD,  target: S_LOAD};
      S_INIT:  w = '{act: A_INIT,  cond: C_OP_OTHER, target: S_FETCH};
      S_PROBE: w = '{act: A_READ,  cond: C_DONE,     target: S_EMIT};
      S_CMP:   w = '{act: A_CMP,   cond: C_ALWAYS,   target: S_PROBE};
      S_EMIT:  w = '{act: A_EMIT,  cond: C_OUT_BUSY, target: S_EMIT};
      S_RET:   w = '{act: A_NONE,  cond: C_ALWAYS,   target: S_FETCH};
      S_CLEAR: w = '{act: A_CLEAR, cond: C_ALWAYS,   target: S_FETCH};
      S_LOAD:  w = '{act: A_LOAD,  cond: C_ALWAYS,   target: S_FETCH};
      default: w = '{act: A_NONE,  cond: C_ALWAYS,   target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/drq_useq.sv
// Step counter and jump logic over the control store in drq_pkg.
// Depends on drq_pkg; condition flags come from drq_dpath.
module drq_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  drq_pkg::flags_t flags_i,
  output drq_pkg::uword_t uword_o
);

  drq_pkg::step_t  step_q, step_d;
  drq_pkg::uword_t uword;
  logic            take;

  assign uword   = drq_pkg::ucode_rom(step_q);
  assign uword_o = uword;

  always_comb begin
    unique case (uword.cond)
      drq_pkg::C_ALWAYS:   take = 1'b1;
      drq_pkg::C_NO_REQ:   take = !flags_i.req;
      drq_pkg::C_OP_CLEAR: take = flags_i.op_clear;
      drq_pkg::C_OP_LOAD:  take = flags_i.op_load;
      drq_pkg::C_OP_OTHER: take = !flags_i.op_query;
      drq_pkg::C_DONE:     take = flags_i.done;
      drq_pkg::C_OUT_BUSY: take = flags_i.out_busy;
      default:             take = 1'b1;
    endcase
    step_d = take ? uword.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= drq_pkg::S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> rtl/drq_dpath.sv
// Datapath: score memory, fill count, search bounds and the result register.
// Depends on drq_pkg; driven by the control word from drq_useq.
module drq_dpath #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  drq_pkg::uword_t               uword_i,
  input  logic                          in_valid_i,
  input  logic [drq_pkg::OP_W-1:0]      opcode_i,
  input  logic [drq_pkg::SCORE_W-1:0]   score_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [drq_pkg::RANK_W-1:0]    rank_o,
  output logic                          overflowed_o,
  output drq_pkg::flags_t               flags_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [drq_pkg::SCORE_W-1:0] mem [TABLE_DEPTH];

  logic [drq_pkg::OP_W-1:0]    op_q;
  logic [drq_pkg::SCORE_W-1:0] score_q, last_q, rdata_q;
  logic [CW-1:0]               cnt_q, lo_q, hi_q, mid_q, mid_d;
  logic                        ovf_q, out_valid_q, out_free;
  logic [drq_pkg::RANK_W-1:0]  rank_q;
  logic                        res_ovf_q;
  logic [CW:0]                 rank_sum;
  logic                        fresh, room;

  assign mid_d    = lo_q + ((hi_q - lo_q) >> 1);
  assign out_free = !out_valid_q || out_ready_i;
  assign rank_sum = {1'b0, lo_q} + 1'b1;
  assign fresh    = (cnt_q == '0) || (score_q < last_q);
  assign room     = cnt_q != CW'(TABLE_DEPTH);

  assign flags_o.req      = in_valid_i;
  assign flags_o.op_clear = op_q == drq_pkg::OP_CLEAR;
  assign flags_o.op_load  = op_q == drq_pkg::OP_LOAD;
  assign flags_o.op_query = op_q == drq_pkg::OP_QUERY;
  assign flags_o.done     = lo_q == hi_q;
  assign flags_o.out_busy = !out_free;

  assign out_valid_o  = out_valid_q;
  assign rank_o       = rank_q;
  assign overflowed_o = res_ovf_q;

  // Table storage: one write port for loads, one registered read for probes.
  always_ff @(posedge clk_i) begin
    if (uword_i.act == drq_pkg::A_LOAD && fresh && room) begin
      mem[cnt_q[AW-1:0]] <= score_q;
    end
    if (uword_i.act == drq_pkg::A_READ) begin
      rdata_q <= mem[mid_d[AW-1:0]];
    end
  end

  // Request payload and the last appended score.
  always_ff @(posedge clk_i) begin
    if (uword_i.act == drq_pkg::A_FETCH && in_valid_i) begin
      op_q    <= opcode_i;
      score_q <= score_i;
    end
    if (uword_i.act == drq_pkg::A_LOAD && fresh && room) begin
      last_q <= score_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      out_valid_q <= 1'b0;
      rank_q      <= '0;
      res_ovf_q   <= 1'b0;
    end else begin
      // Latch the overflow mark with the rank so a waiting result holds still.
      if (uword_i.act == drq_pkg::A_EMIT && out_free) begin
        out_valid_q <= 1'b1;
        rank_q      <= drq_pkg::RANK_W'(rank_sum);
        res_ovf_q   <= ovf_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (uword_i.act)
        drq_pkg::A_CLEAR: cnt_q <= '0;
        drq_pkg::A_LOAD: begin
          if (fresh) begin
            if (room) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        drq_pkg::A_INIT: begin
          lo_q <= '0;
          hi_q <= cnt_q;
        end
        drq_pkg::A_READ: mid_q <= mid_d;
        drq_pkg::A_CMP: begin
          // Entries above the score sit before the boundary: move lo past them.
          if (rdata_q > score_q) begin
            lo_q <= mid_q + 1'b1;
          end else begin
            hi_q <= mid_q;
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search bounds crossed");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow mark dropped");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword_i.act == drq_pkg::A_LOAD && !room) |=> $stable(cnt_q))
    else $error("load grew a full table");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=>
      (out_valid_q && $stable(rank_q) && $stable(res_ovf_q)))
    else $error("waiting result changed");

endmodule

>>> rtl/dense_rank_query_engine.sv
// A query makes at most floor(log2(n)) + 1 binary search probes for n stored scores. Each
// probe is a read step and then a compare step, because the single table read port returns
// registered data before the compare. One request is in work at a time; a finished rank
// waits in the output register while the next request is taken, and a query holds in its
// emit step while an earlier rank still waits. Loads keep the table strictly descending
// and set a sticky overflow mark when a fresh score is dropped on a full table; only reset
// clears that mark, clear keeps it.
// Top level: instantiates drq_useq and drq_dpath, uses drq_pkg.
module dense_rank_query_engine #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [drq_pkg::OP_W-1:0]    opcode_i,
  input  logic [drq_pkg::SCORE_W-1:0] score_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [drq_pkg::RANK_W-1:0]  rank_o,
  output logic                        overflowed_o
);

  drq_pkg::uword_t uword;
  drq_pkg::flags_t flags;

  assign in_ready_o = uword.act == drq_pkg::A_FETCH;

  drq_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uword)
  );

  drq_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .uword_i      (uword),
    .in_valid_i   (in_valid_i),
    .opcode_i     (opcode_i),
    .score_i      (score_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .rank_o       (rank_o),
    .overflowed_o (overflowed_o),
    .flags_o      (flags)
  );

endmodule

>>> dv/dense_rank_query_engine_tb.sv
// Testbench for dense_rank_query_engine: drives clear, load and query requests and
// scores every returned rank and overflow mark against a ranking ledger kept in the bench.
// Depends on drq_pkg and the dense_rank_query_engine RTL.
`timescale 1ns / 1ps

module dense_rank_query_engine_tb;

  localparam int unsigned DEPTH           = 1024;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES     = 60;
  localparam int unsigned CYCLE_LIMIT     = 800000;

  // Opcode that the block ignores.
  localparam logic [drq_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [drq_pkg::RANK_W-1:0] rank;
    logic                       ovf;
  } rank_rec_t;

  // Ledger of stored scores; predicts every query's rank and checks it on return.
  class rank_ledger;
    bit [drq_pkg::SCORE_W-1:0] ladder [DEPTH];
    int unsigned               filled;
    bit                        spilled;
    rank_rec_t                 due_ranks[$];
    int unsigned               errors;

    task report(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    function bit [drq_pkg::SCORE_W-1:0] tail_score();
      return (filled == 0) ? '1 : ladder[filled-1];
    endfunction

    function void note_request(logic [drq_pkg::OP_W-1:0] op,
                               logic [drq_pkg::SCORE_W-1:0] s);
      rank_rec_t   r;
      int unsigned above;
      case (op)
        drq_pkg::OP_CLEAR: filled = 0;
        drq_pkg::OP_LOAD: begin
          if (filled == 0 || s < ladder[filled-1]) begin
            if (filled < DEPTH) begin
              ladder[filled] = s;
              filled++;
            end else begin
              spilled = 1'b1;
            end
          end
        end
        drq_pkg::OP_QUERY: begin
          above = 0;
          for (int i = 0; i < filled; i++) if (ladder[i] > s) above++;
          r.rank = drq_pkg::RANK_W'(above + 1);
          r.ovf  = spilled;
          due_ranks = {due_ranks, r};
        end
        default: ;
      endcase
    endfunction

    task check_rank(logic [drq_pkg::RANK_W-1:0] rank, logic ovf);
      rank_rec_t want;
      if (due_ranks.size() == 0) begin
        report($sformatf("rank %0d returned with no query waiting", rank));
      end else begin
        want = due_ranks.pop_front();
        if (rank !== want.rank)
          report($sformatf("rank %0d, expected %0d", rank, want.rank));
        if (ovf !== want.ovf)
          report($sformatf("overflowed %b, expected %b", ovf, want.ovf));
      end
    endtask

    task close_out();
      while (due_ranks.size() != 0) begin
        report("query never answered");
        void'(due_ranks.pop_front());
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [drq_pkg::OP_W-1:0]      opcode_i;
  logic [drq_pkg::SCORE_W-1:0]   score_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [drq_pkg::RANK_W-1:0]    rank_o;
  logic                          overflowed_o;

  rank_ledger  board;
  bit          idling_on;
  int unsigned hold_off_asks;
  int unsigned hold_off_done;
  int unsigned stall_left;
  int unsigned items;
  int unsigned cycles;

  dense_rank_query_engine #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .score_i     (score_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rank_o      (rank_o),
    .overflowed_o(overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offer one request and hold it until accepted.
  task automatic send_request(input logic [drq_pkg::OP_W-1:0] op,
                              input logic [drq_pkg::SCORE_W-1:0] s);
    if (idling_on && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    score_i    <= s;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(op, s);
    if (op != OP_SPARE) items++;
  endtask

  // Stop offering until every outstanding rank has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.due_ranks.size() != 0);
  endtask

  function automatic logic [drq_pkg::SCORE_W-1:0] pick_query();
    logic [drq_pkg::SCORE_W-1:0] e;
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return '0;
      2: return '1;
      default: begin
        if (board.filled == 0) return $urandom;
        e = board.ladder[$urandom_range(0, board.filled - 1)];
        case ($urandom_range(0, 2))
          0: return e - 1;
          1: return e + 1;
          default: return e;
        endcase
      end
    endcase
  endfunction

  task automatic send_query();
    send_request(drq_pkg::OP_QUERY, pick_query());
  endtask

  task automatic run_directed();
    send_request(drq_pkg::OP_QUERY, 32'h0);
    send_request(drq_pkg::OP_QUERY, 32'hFFFF_FFFF);
    send_request(OP_SPARE, 32'hA5A5_5A5A);
    send_request(drq_pkg::OP_LOAD, 32'hFFFF_FFFF);
    send_request(drq_pkg::OP_LOAD, 32'hFFFF_FFFF);   // repeat, drop
    send_request(drq_pkg::OP_LOAD, 32'd1000);
    send_request(drq_pkg::OP_LOAD, 32'd2000);        // out of order, drop
    send_request(drq_pkg::OP_LOAD, 32'd1000);
    send_request(drq_pkg::OP_LOAD, 32'h0);
    send_request(drq_pkg::OP_QUERY, 32'hFFFF_FFFF);
    send_request(drq_pkg::OP_QUERY, 32'hFFFF_FFFE);
    send_request(drq_pkg::OP_QUERY, 32'd1000);
    send_request(drq_pkg::OP_QUERY, 32'd999);
    send_request(drq_pkg::OP_QUERY, 32'h0);
    send_request(OP_SPARE, 32'h0);
    send_request(drq_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    send_request(drq_pkg::OP_QUERY, 32'd5);
    send_request(drq_pkg::OP_LOAD, 32'd7);
    send_request(drq_pkg::OP_QUERY, 32'd7);
    send_request(drq_pkg::OP_QUERY, 32'd6);
    send_request(drq_pkg::OP_QUERY, 32'd8);
  endtask

  // Well-formed descending runs with queries mixed in, plus some noise.
  task automatic run_random(input int unsigned target);
    int unsigned                 n;
    int unsigned                 span;
    logic [drq_pkg::SCORE_W-1:0] tail;
    logic [drq_pkg::SCORE_W-1:0] step;
    while (items < target) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) send_request(drq_pkg::OP_CLEAR, $urandom);
        n    = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 120 : 24);
        span = $urandom_range(0, 3);
        repeat (n) begin
          tail = board.tail_score();
          case (span)
            0:       step = $urandom_range(1, 3);
            1:       step = $urandom_range(1, 255);
            2:       step = $urandom_range(1, 32'h0010_0000);
            default: step = $urandom_range(1, 32'h0800_0000);
          endcase
          case ($urandom_range(0, 11))
            0: send_request(drq_pkg::OP_LOAD, tail);
            1: send_request(drq_pkg::OP_LOAD, tail + $urandom_range(1, 100));
            default: begin
              if (board.filled == 0) send_request(drq_pkg::OP_LOAD, $urandom);
              else send_request(drq_pkg::OP_LOAD, (step > tail) ? '0 : tail - step);
            end
          endcase
          if ($urandom_range(0, 2) == 0) send_query();
        end
        repeat ($urandom_range(1, 6)) send_query();
      end else begin
        send_request(2'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  // Fill the table to the brim, then probe the full-table and overflow cases.
  task automatic run_fill();
    logic [drq_pkg::SCORE_W-1:0] s;
    send_request(drq_pkg::OP_CLEAR, 32'h0);
    s = 32'hFFFF_FFFF;
    for (int i = 0; i < DEPTH; i++) begin
      send_request(drq_pkg::OP_LOAD, s);
      if (i % 97 == 0) send_query();
      s = s - $urandom_range(1, 4000000);
    end
    send_request(drq_pkg::OP_QUERY, 32'h0);              // rank one past the table
    send_request(drq_pkg::OP_QUERY, 32'hFFFF_FFFF);
    send_request(drq_pkg::OP_LOAD, board.tail_score());  // repeat on a full table
    send_request(drq_pkg::OP_LOAD, 32'hFFFF_FFFF);       // out of order on a full table
    send_request(drq_pkg::OP_QUERY, pick_query());
    send_request(drq_pkg::OP_LOAD, 32'h0);               // fresh on a full table, sets the mark
    send_request(drq_pkg::OP_QUERY, pick_query());
    send_request(drq_pkg::OP_LOAD, 32'h0);
    send_request(drq_pkg::OP_CLEAR, $urandom);           // mark survives a clear
    send_request(drq_pkg::OP_QUERY, 32'h0);
    send_request(drq_pkg::OP_LOAD, 32'd50);
    send_request(drq_pkg::OP_QUERY, 32'd49);
  endtask

  // Result side: random stalls, and a long hold-off on request.
  initial begin
    out_ready_i   = 1'b0;
    hold_off_done = 0;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) board.check_rank(rank_o, overflowed_o);
      if (hold_off_done != hold_off_asks) begin
        hold_off_done = hold_off_asks;
        stall_left    = HOLD_OFF_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("dense_rank_query_engine verification failed");
    $finish;
  end

  initial begin
    board         = new();
    idling_on     = 1'b1;
    hold_off_asks = 0;
    items         = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = drq_pkg::OP_CLEAR;
    score_i       = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(100);
    hold_off_asks++;
    repeat (12) send_query();
    run_random(items + 60);
    wait_drained();
    run_fill();
    run_random(items + 50);
    wait_drained();
    hold_off_asks++;
    repeat (12) send_query();
    run_random(items + 30);
    idling_on = 1'b0;
    run_random(items + 40);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    board.close_out();
    if (board.errors == 0) begin
      $display("dense_rank_query_engine verification clean");
    end else begin
      $display("dense_rank_query_engine verification failed");
    end
    $finish;
  end

endmodule
